>>> rtl/core/spi9_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi9_pkg
// Shared types and constants of the three-wire 9-bit command writer.
// ----------------------------------------------------------------------------
package spi9_pkg;

    localparam int HALF_W = 16;
    localparam logic [HALF_W-1:0] RESET_HALF_PERIOD = 16'd200;
    localparam logic [1:0] MAX_DATA_BYTES = 2'd2;

    typedef struct packed {
        logic        func;
        logic [1:0]  data_bytes;
        logic [7:0]  reg_addr;
        logic [15:0] data_value;
        logic        din;
    } t_item;

    typedef struct packed {
        logic error;
        logic done_res;
        logic busy_res;
        logic sda;
        logic scl;
        logic cs_n;
    } t_result;

endpackage

>>> rtl/core/spi_9bit_command_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_9bit_command_writer
// Tick-driven three-wire 9-bit serial master with loopback check.
// ----------------------------------------------------------------------------
// Every input item is one timing tick and yields exactly one result item with
// the serial line states after that tick. The block takes one item per clock
// cycle while the result register is free; a result is offered once its item
// has passed the input register and its combinational line step has been
// loaded into the result register. Both registers advance together whenever
// the input register holds an item and the result register is free.
// ----------------------------------------------------------------------------
module spi_9bit_command_writer #(
    parameter int WORD_BITS = 9,
    parameter int MAX_WORDS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spi9_pkg::HALF_W-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] data_bytes, [9:2] reg_addr, [25:10] data_value, [26] din
    input  logic [31:0]                 s_axis_tdata,
    // [0] func
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] cs_n, [1] scl, [2] sda, [3] busy_res, [4] done_res, [5] error
    output logic [7:0]                  m_axis_tdata
);
    import spi9_pkg::*;

    logic [HALF_W-1:0] r_half_period;
    logic              r_in_valid;
    t_item             r_in_item;
    t_result           step_res;
    t_result           out_res;
    logic              out_free;
    logic              adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= RESET_HALF_PERIOD;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.func       <= s_axis_tuser;
            r_in_item.data_bytes <= s_axis_tdata[1:0];
            r_in_item.reg_addr   <= s_axis_tdata[9:2];
            r_in_item.data_value <= s_axis_tdata[25:10];
            r_in_item.din        <= s_axis_tdata[26];
        end
    end

    spi9_engine #(
        .WORD_BITS (WORD_BITS),
        .MAX_WORDS (MAX_WORDS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_item        (r_in_item),
        .i_half_period (r_half_period),
        .o_res         (step_res)
    );

    spi9_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (step_res),
        .i_take  (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res};

    a_error_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_res.error |-> out_res.done_res)
        else $error("error flag without done");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_res.done_res |-> !out_res.busy_res && out_res.cs_n)
        else $error("done while still busy or selected");

    a_busy_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_res.busy_res |-> !out_res.cs_n)
        else $error("busy with chip select high");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

>>> rtl/core/spi9_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi9_engine
// Serial line state and the one-tick step of the writer: loads a command
// write, times the clock halves, shifts bits and checks the loopback line.
// ----------------------------------------------------------------------------
module spi9_engine #(
    parameter int WORD_BITS = 9,
    parameter int MAX_WORDS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  spi9_pkg::t_item               i_item,
    input  logic [spi9_pkg::HALF_W-1:0]   i_half_period,
    output spi9_pkg::t_result             o_res
);
    import spi9_pkg::*;

    localparam int TOTAL_BITS = WORD_BITS * MAX_WORDS;
    localparam int PAY_BITS   = WORD_BITS - 1;
    localparam int BL_W       = $clog2(WORD_BITS);
    localparam int WL_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [TOTAL_BITS-1:0] r_shift, n_shift;
    logic [WL_W-1:0]       r_words, n_words;
    logic [BL_W-1:0]       r_bits, n_bits;
    logic                  r_high, n_high;
    logic [HALF_W-1:0]     r_delay, n_delay;
    logic                  r_active, n_active;
    logic                  r_cs, n_cs;
    logic                  r_clk, n_clk;
    logic                  r_data, n_data;

    logic [HALF_W-1:0]     half_m1;
    logic [1:0]            nb;
    logic [2:0]            word_cnt;
    logic [WORD_BITS-1:0]  word;
    logic                  done;
    logic                  err;

    function automatic logic [PAY_BITS-1:0] f_pay(input logic [7:0] b);
        logic [15:0] ext;
        ext = {8'h00, b};
        return ext[PAY_BITS-1:0];
    endfunction

    assign half_m1 = (i_half_period == '0) ? '0 : i_half_period - 1'b1;

    always_comb begin
        n_shift  = r_shift;
        n_words  = r_words;
        n_bits   = r_bits;
        n_high   = r_high;
        n_delay  = r_delay;
        n_active = r_active;
        n_cs     = r_cs;
        n_clk    = r_clk;
        n_data   = r_data;
        done     = 1'b0;
        err      = 1'b0;
        nb       = (i_item.data_bytes > MAX_DATA_BYTES) ? MAX_DATA_BYTES : i_item.data_bytes;
        word_cnt = {1'b0, nb} + 3'd1;
        if (word_cnt > 3'(MAX_WORDS)) begin
            word_cnt = 3'(MAX_WORDS);
        end
        word = '0;

        if (!r_active && i_item.func) begin
            n_shift = '0;
            for (int k = 0; k < MAX_WORDS; k++) begin
                if (k == 0) begin
                    word = {1'b0, f_pay(i_item.reg_addr)};
                end else if (k == 1) begin
                    word = {1'b1, f_pay((nb == 2'd1) ? i_item.data_value[7:0]
                                                      : i_item.data_value[15:8])};
                end else if (k == 2) begin
                    word = {1'b1, f_pay(i_item.data_value[7:0])};
                end else begin
                    word = '0;
                end
                if (3'(k) < word_cnt) begin
                    n_shift[TOTAL_BITS-1-k*WORD_BITS -: WORD_BITS] = word;
                end
            end
            n_words  = WL_W'(word_cnt - 3'd1);
            n_bits   = BL_W'(WORD_BITS - 1);
            n_high   = 1'b0;
            n_delay  = half_m1;
            n_active = 1'b1;
            n_cs     = 1'b0;
        end

        if (n_active) begin
            if (!n_high) begin
                n_clk  = 1'b0;
                n_data = n_shift[TOTAL_BITS-1];
                if (n_delay == '0) begin
                    if (i_item.din != n_data) begin
                        n_active = 1'b0;
                        n_cs     = 1'b1;
                        n_clk    = 1'b1;
                        done     = 1'b1;
                        err      = 1'b1;
                    end else begin
                        n_high  = 1'b1;
                        n_delay = half_m1;
                    end
                end else begin
                    n_delay = n_delay - 1'b1;
                end
            end else begin
                n_clk = 1'b1;
                if (n_delay == '0) begin
                    if (n_bits != '0 || n_words != '0) begin
                        if (n_bits != '0) begin
                            n_bits = n_bits - 1'b1;
                        end else begin
                            n_words = n_words - 1'b1;
                            n_bits  = BL_W'(WORD_BITS - 1);
                        end
                        n_shift = {n_shift[TOTAL_BITS-2:0], 1'b0};
                        n_high  = 1'b0;
                        n_delay = half_m1;
                    end else begin
                        n_active = 1'b0;
                        n_cs     = 1'b1;
                        done     = 1'b1;
                    end
                end else begin
                    n_delay = n_delay - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_words  <= '0;
            r_bits   <= '0;
            r_high   <= 1'b0;
            r_delay  <= '0;
            r_active <= 1'b0;
            r_cs     <= 1'b1;
            r_clk    <= 1'b1;
            r_data   <= 1'b0;
        end else if (i_adv) begin
            r_shift  <= n_shift;
            r_words  <= n_words;
            r_bits   <= n_bits;
            r_high   <= n_high;
            r_delay  <= n_delay;
            r_active <= n_active;
            r_cs     <= n_cs;
            r_clk    <= n_clk;
            r_data   <= n_data;
        end
    end

    assign o_res.cs_n     = n_cs;
    assign o_res.scl      = n_clk;
    assign o_res.sda      = n_data;
    assign o_res.busy_res = n_active;
    assign o_res.done_res = done;
    assign o_res.error    = err;

endmodule

>>> rtl/core/spi9_bit_writer_top_placeholder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi9_out_reg
// Result register of the writer: holds one finished item until the
// downstream side takes it, while the next item may already be computed.
// ----------------------------------------------------------------------------
module spi9_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  spi9_pkg::t_result i_res,
    input  logic              i_take,
    output logic              o_valid,
    output logic              o_free,
    output spi9_pkg::t_result o_res
);
    import spi9_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_free  = !r_valid || i_take;
    assign o_res   = r_res;

endmodule

>>> tb/spi9_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi9_line_checker
// Watches both streams of the 9-bit command writer and checks every result.
// ----------------------------------------------------------------------------
// Each accepted tick is run through a local model of the serial engine. The
// model gives the line states that the block must return for that tick, and
// they are queued in order. Each returned item is compared field by field
// with the oldest queued state. The model's busy flag and next driven bit are
// exported so that the stimulus can answer the loopback check.
// ----------------------------------------------------------------------------
module spi9_line_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spi9_pkg::HALF_W-1:0] i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    input  logic                        i_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,
    input  logic                        i_s_axis_tuser,
    input  logic                        i_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [7:0]                  i_m_axis_tdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output logic                        o_busy,
    output logic                        o_next_bit
);
    import spi9_pkg::*;

    localparam int FRAME_BITS = 27;
    localparam logic [3:0] LAST_BIT_IDX = 4'd8;

    logic [HALF_W-1:0]     half_q;
    logic [FRAME_BITS-1:0] frame_sr;
    logic [1:0]            words_left;
    logic [3:0]            bits_left;
    logic                  in_high_half;
    logic [HALF_W-1:0]     ticks_left;
    logic                  write_active;
    logic                  cs_line;
    logic                  scl_line;
    logic                  sda_line;

    t_result line_states_q[$];

    assign o_busy     = write_active;
    assign o_next_bit = frame_sr[FRAME_BITS-1];

    function automatic t_result advance_serial_tick(input logic       start,
                                                    input logic [1:0]  data_bytes,
                                                    input logic [7:0]  reg_addr,
                                                    input logic [15:0] data_value,
                                                    input logic        din);
        t_result           r;
        logic [1:0]        nbytes;
        logic [HALF_W-1:0] eff_half;
        eff_half = (half_q == '0) ? 16'd1 : half_q;
        r.done_res = 1'b0;
        r.error = 1'b0;
        if (!write_active && start) begin
            nbytes = (data_bytes > MAX_DATA_BYTES) ? MAX_DATA_BYTES : data_bytes;
            case (nbytes)
                2'd0: frame_sr = {1'b0, reg_addr, 18'd0};
                2'd1: frame_sr = {1'b0, reg_addr, 1'b1, data_value[7:0], 9'd0};
                default: frame_sr = {1'b0, reg_addr, 1'b1, data_value[15:8],
                                     1'b1, data_value[7:0]};
            endcase
            words_left = nbytes;
            bits_left = LAST_BIT_IDX;
            in_high_half = 1'b0;
            ticks_left = eff_half - 16'd1;
            write_active = 1'b1;
            cs_line = 1'b0;
        end
        if (write_active) begin
            if (!in_high_half) begin
                scl_line = 1'b0;
                sda_line = frame_sr[FRAME_BITS-1];
                if (ticks_left == '0) begin
                    if (din != sda_line) begin
                        write_active = 1'b0;
                        cs_line = 1'b1;
                        scl_line = 1'b1;
                        r.done_res = 1'b1;
                        r.error = 1'b1;
                    end else begin
                        in_high_half = 1'b1;
                        ticks_left = eff_half - 16'd1;
                    end
                end else begin
                    ticks_left = ticks_left - 16'd1;
                end
            end else begin
                scl_line = 1'b1;
                if (ticks_left == '0) begin
                    if (bits_left != '0 || words_left != '0) begin
                        if (bits_left != '0) begin
                            bits_left = bits_left - 4'd1;
                        end else begin
                            words_left = words_left - 2'd1;
                            bits_left = LAST_BIT_IDX;
                        end
                        frame_sr = frame_sr << 1;
                        in_high_half = 1'b0;
                        ticks_left = eff_half - 16'd1;
                    end else begin
                        write_active = 1'b0;
                        cs_line = 1'b1;
                        r.done_res = 1'b1;
                    end
                end else begin
                    ticks_left = ticks_left - 16'd1;
                end
            end
        end
        r.cs_n = cs_line;
        r.scl = scl_line;
        r.sda = sda_line;
        r.busy_res = write_active;
        return r;
    endfunction

    task automatic check_line(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            half_q = RESET_HALF_PERIOD;
            frame_sr = '0;
            words_left = '0;
            bits_left = '0;
            in_high_half = 1'b0;
            ticks_left = '0;
            write_active = 1'b0;
            cs_line = 1'b1;
            scl_line = 1'b1;
            sda_line = 1'b0;
            line_states_q.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(i_m_axis_tdata[5:0]);
                if (line_states_q.size() == 0) begin
                    $error("result item arrived with no tick outstanding");
                    o_fail_count++;
                end else begin
                    want = line_states_q.pop_front();
                    check_line("cs_n", want.cs_n, got.cs_n);
                    check_line("scl", want.scl, got.scl);
                    check_line("sda", want.sda, got.sda);
                    check_line("busy_res", want.busy_res, got.busy_res);
                    check_line("done_res", want.done_res, got.done_res);
                    check_line("error", want.error, got.error);
                end
            end
            if (i_cfg_we) begin
                half_q = i_cfg_wdata;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                line_states_q.push_back(advance_serial_tick(i_s_axis_tuser,
                                                            i_s_axis_tdata[1:0],
                                                            i_s_axis_tdata[9:2],
                                                            i_s_axis_tdata[25:10],
                                                            i_s_axis_tdata[26]));
            end
        end
        o_pending = line_states_q.size();
    end

endmodule

>>> tb/tb_spi_9bit_command_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_9bit_command_writer
// Stimulus and verdict for the three-wire 9-bit command writer.
// ----------------------------------------------------------------------------
// Register writes are issued as start ticks followed by plain ticks until the
// write ends. The loopback input normally echoes the bit being driven, so that
// full frames go out; faults are injected by inverting it from a chosen tick
// on. A directed part covers the reset half period, zero, one and a long half
// period, byte counts zero to three, extreme payloads, starts while busy and
// aborts on the first and last bits. A random part then runs more writes at
// small half periods. The sender idles in bursts and the receiver stalls on
// its own pattern; a separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_spi_9bit_command_writer;
    import spi9_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [HALF_W-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;

    int   chk_fails;
    int   chk_pending;
    logic chk_busy;
    logic chk_next_bit;

    int burst_left = 0;
    int idling_on = 1;
    int busy_start_pct = 0;
    int ticks_sent = 0;
    int writes_issued = 0;
    int faults_injected = 0;
    int half_settings = 1;
    int cur_half = 200;
    int stall_left = 0;
    int stall_pct = 0;
    int pattern_left = 0;

    spi_9bit_command_writer uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    spi9_line_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(s_axis_tvalid),
        .i_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_s_axis_tuser (s_axis_tuser),
        .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_m_axis_tdata (m_axis_tdata),
        .o_fail_count   (chk_fails),
        .o_pending      (chk_pending),
        .o_busy         (chk_busy),
        .o_next_bit     (chk_next_bit)
    );

    always #1 i_clk = ~i_clk;

    // The receiver switches at random between three stall densities.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 12);
            end
        end
        if (pattern_left == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 5;
                default: stall_pct = 25;
            endcase
            pattern_left = $urandom_range(200, 2000);
        end else begin
            pattern_left--;
        end
    end

    // Called and returns at a falling edge. The loopback bit echoes the bit
    // that the next tick drives, inverted when invert is set.
    task automatic send_tick(input logic f, input logic [1:0] nbytes,
                             input logic [7:0] reg_addr, input logic [15:0] value,
                             input logic invert);
        logic echo;
        if (idling_on != 0 && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        echo = (f && !chk_busy) ? 1'b0 : chk_next_bit;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {5'd0, echo ^ invert, value, reg_addr, nbytes};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
    endtask

    task automatic set_half_period(input logic [HALF_W-1:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_half = (value == '0) ? 1 : int'(value);
        half_settings++;
    endtask

    // A fault_at below zero leaves the loopback clean for the whole write.
    task automatic run_write(input logic [1:0] nbytes, input logic [7:0] reg_addr,
                             input logic [15:0] value, input int fault_at,
                             input logic hold_mid);
        int tick_no;
        tick_no = 0;
        writes_issued++;
        if (fault_at >= 0) begin
            faults_injected++;
        end
        send_tick(1'b1, nbytes, reg_addr, value, fault_at == 0);
        while (chk_busy) begin
            tick_no++;
            if (hold_mid && tick_no == 5) begin
                drain_results();
            end
            send_tick($urandom_range(0, 99) < busy_start_pct, 2'($urandom_range(0, 3)),
                      8'($urandom), 16'($urandom), fault_at >= 0 && tick_no >= fault_at);
        end
    endtask

    initial begin
        int rand_writes;
        int next_change;
        logic [1:0] nbytes;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_write(2'd1, 8'hFF, 16'h00FF, 0, 1'b0);

        set_half_period(16'd1);
        run_write(2'd0, 8'h00, 16'h0000, -1, 1'b0);
        busy_start_pct = 30;
        run_write(2'd2, 8'hFF, 16'hFFFF, -1, 1'b0);
        busy_start_pct = 0;
        run_write(2'd2, 8'h00, 16'h0000, -1, 1'b0);
        run_write(2'd3, 8'hA5, 16'h5AC3, -1, 1'b0);
        run_write(2'd1, 8'h3C, 16'hFF00, -1, 1'b0);
        run_write(2'd1, 8'hC3, 16'h00FF, 0, 1'b0);
        run_write(2'd2, 8'h81, 16'h8001, 52, 1'b0);
        run_write(2'd0, 8'h7E, 16'h0000, 16, 1'b0);

        set_half_period(16'd0);
        run_write(2'd2, 8'h5A, 16'h1234, -1, 1'b1);

        set_half_period(16'd100);
        run_write(2'd0, 8'h12, 16'h0000, 0, 1'b0);

        rand_writes = 0;
        next_change = 0;
        busy_start_pct = 2;
        while (rand_writes < 11) begin
            if (rand_writes == next_change) begin
                case ($urandom_range(0, 4))
                    0: set_half_period(16'd0);
                    1, 2: set_half_period(16'd1);
                    3: set_half_period(16'd2);
                    default: set_half_period(16'd3);
                endcase
                next_change = rand_writes + $urandom_range(2, 4);
            end
            idling_on = ($urandom_range(0, 3) != 0);
            nbytes = 2'($urandom_range(0, 3));
            run_write(nbytes, 8'($urandom), 16'($urandom),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 54 * cur_half) : -1,
                      $urandom_range(0, 9) == 0);
            repeat ($urandom_range(0, 3)) begin
                send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                          1'($urandom_range(0, 1)));
            end
            rand_writes++;
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d ticks carrying %0d write requests, %0d of them with a loopback fault,",
                 ticks_sent, writes_issued, faults_injected);
        $display("across %0d half-period settings.", half_settings);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> spi_9bit_command_writer.f
rtl/core/spi9_pkg.sv
rtl/core/spi9_engine.sv
rtl/core/spi9_bit_writer_top_placeholder.sv
rtl/core/spi_9bit_command_writer.sv
tb/spi9_line_checker.sv
tb/tb_spi_9bit_command_writer.sv
